// ----- rtl/pwl_pkg.sv -----
// ----------------------------------------------------------------------------
// pwl_pkg
// shared types and constants of the piecewise linear table interpolator
// ----------------------------------------------------------------------------
package pwl_pkg;

  localparam int unsigned TableDepth = 256;
  localparam int unsigned AddrW      = 8;
  localparam int unsigned LenW       = 9;
  localparam int unsigned DataW      = 32;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBelow    = 2'd1;
  localparam logic [1:0] StAbove    = 2'd2;
  localparam logic [1:0] StBadIndex = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_LASTD,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SEL,
    S_CLAMP,
    S_RDL,
    S_RDR,
    S_DIFF,
    S_MUL,
    S_DIV,
    S_RND,
    S_SUM,
    S_FINISH
  } pwl_state_e;

endpackage

// ----- rtl/pwl_ram.sv -----
// ----------------------------------------------------------------------------
// pwl_ram
// generic single-clock ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
module pwl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- rtl/piecewise_linear_table_interp_core.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core
// knot table in one ram, binary search for the segment, linear interpolation
// write beat: result passes through S_FINISH to the output register; query
// beat: each search step reads the ram in S_SRCH_RD and compares in
// S_SRCH_CMP, then a radix-4 restoring divider runs in S_DIV;
// clamped and degenerate queries skip the divider
// one beat at a time; the next input is taken while a result waits on m_axis
// reset clears control only; the knot table is undefined until written
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp_core
  import pwl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,   // table_length
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // entry_index, x_value, y_value
  input  logic [0:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // y_result, segment_index, status, pad
);

  pwl_state_e state_q, state_d;

  logic [LenW-1:0]  len_q;
  logic [LenW-1:0]  n_eff;
  logic [LenW-1:0]  n_q;
  logic [DataW-1:0] q_q, first_q, last_q;
  logic             asc_q;
  logic [LenW-1:0]  lo_q, hi_q, j_q;
  logic [DataW-1:0] lx_q, ly_q, rx_q, ry_q;
  logic [DataW-1:0] ax_q, ay_q, aq_q;
  logic             neg_q, degen_q;
  logic [63:0]      w_q;
  logic [DataW-1:0] rem_q;
  logic [4:0]       cnt_q;
  logic [33:0]      corr_q;
  logic [DataW-1:0] res_y_q;
  logic [7:0]       res_seg_q;
  logic [1:0]       res_st_q;
  logic             out_valid_q;
  logic [DataW-1:0] out_y_q;
  logic [7:0]       out_seg_q;
  logic [1:0]       out_st_q;

  logic             in_acc;
  logic [7:0]       in_idx;
  logic [DataW-1:0] in_x, in_y;
  logic             wr_ok;
  logic [AddrW-1:0] raddr;
  logic [63:0]      rdata;
  logic [DataW-1:0] rd_x, rd_y;
  logic [9:0]       mid_sum;
  logic [LenW-1:0]  mid;
  logic             cmp_ge, cmp_up;
  logic [LenW-1:0]  lo_n, hi_n;
  logic [LenW-1:0]  j_sel;
  logic             out_free;

  logic [32:0] dx, dy, dq;
  logic [DataW-1:0] w_rem;
  logic [63:0] w_div;
  logic [32:0] t_div, s_div;
  logic        ge_div;
  logic        rnd_inc;
  logic [64:0] quo_r;
  logic [35:0] sum_ext;

  assign in_idx = s_axis_tdata[7:0];
  assign in_x   = s_axis_tdata[39:8];
  assign in_y   = s_axis_tdata[71:40];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    n_eff = len_q;
    if (len_q < LenW'(2)) begin
      n_eff = LenW'(2);
    end else if (len_q > LenW'(TableDepth)) begin
      n_eff = LenW'(TableDepth);
    end
  end

  assign wr_ok = in_acc && (s_axis_tuser[0] == OpWrite) && ({1'b0, in_idx} < n_eff);

  assign rd_x = rdata[31:0];
  assign rd_y = rdata[63:32];

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[LenW:1];
  assign cmp_ge  = $signed(q_q) >= $signed(rd_x);
  assign cmp_up  = (cmp_ge == asc_q);
  assign lo_n    = cmp_up ? mid : lo_q;
  assign hi_n    = cmp_up ? hi_q : mid;

  always_comb begin
    if (q_q == first_q) begin
      j_sel = LenW'(1);
    end else if (q_q == last_q) begin
      j_sel = n_q - LenW'(1);
    end else begin
      j_sel = lo_q;
    end
  end

  // ram read address
  always_comb begin
    raddr = '0;
    unique case (state_q)
      S_LAST:    raddr = AddrW'(n_q - LenW'(1));
      S_SRCH_RD: raddr = AddrW'(mid - LenW'(1));
      S_SEL: begin
        if (j_sel == '0) begin
          raddr = '0;
        end else if (j_sel >= n_q) begin
          raddr = AddrW'(n_q - LenW'(1));
        end else begin
          raddr = AddrW'(j_sel - LenW'(1));
        end
      end
      S_RDL:     raddr = j_q[AddrW-1:0];
      default:   raddr = '0;
    endcase
  end

  pwl_ram #(
    .WIDTH (64),
    .DEPTH (TableDepth)
  ) u_knot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (in_idx),
    .wdata_i ({in_y, in_x}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // segment differences
  assign dx = {rx_q[31], rx_q} - {lx_q[31], lx_q};
  assign dy = {ry_q[31], ry_q} - {ly_q[31], ly_q};
  assign dq = {q_q[31], q_q} - {lx_q[31], lx_q};

  // two restoring divide steps per cycle
  always_comb begin
    w_rem  = rem_q;
    w_div  = w_q;
    t_div  = '0;
    s_div  = '0;
    ge_div = 1'b0;
    for (int k = 0; k < 2; k++) begin
      t_div  = {w_rem, w_div[63]};
      s_div  = t_div - {1'b0, ax_q};
      ge_div = t_div >= {1'b0, ax_q};
      w_rem  = ge_div ? s_div[31:0] : t_div[31:0];
      w_div  = {w_div[62:0], ge_div};
    end
  end

  assign rnd_inc = {rem_q, 1'b0} >= {1'b0, ax_q};
  assign quo_r   = {1'b0, w_q} + 65'(rnd_inc);
  assign sum_ext = neg_q ? ({{4{ly_q[31]}}, ly_q} - {2'b00, corr_q})
                         : ({{4{ly_q[31]}}, ly_q} + {2'b00, corr_q});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (s_axis_tuser[0] == OpQuery) ? S_FIRST : S_FINISH;
        end
      end
      S_FIRST:    state_d = S_LAST;
      S_LAST:     state_d = S_LASTD;
      S_LASTD:    state_d = S_SRCH_RD;
      S_SRCH_RD:  state_d = S_SRCH_CMP;
      S_SRCH_CMP: state_d = ((hi_n - lo_n) > LenW'(1)) ? S_SRCH_RD : S_SEL;
      S_SEL: begin
        state_d = ((j_sel == '0) || (j_sel >= n_q)) ? S_CLAMP : S_RDL;
      end
      S_CLAMP:    state_d = S_FINISH;
      S_RDL:      state_d = S_RDR;
      S_RDR:      state_d = S_DIFF;
      S_DIFF:     state_d = S_MUL;
      S_MUL:      state_d = degen_q ? S_FINISH : S_DIV;
      S_DIV:      state_d = (cnt_q == 5'd31) ? S_RND : S_DIV;
      S_RND:      state_d = S_SUM;
      S_SUM:      state_d = S_FINISH;
      S_FINISH:   state_d = out_free ? S_IDLE : S_FINISH;
      default:    state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LenW'(2);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
      if ((state_q == S_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        n_q       <= n_eff;
        q_q       <= in_x;
        res_y_q   <= '0;
        res_seg_q <= '0;
        res_st_q  <= wr_ok || (s_axis_tuser[0] == OpQuery) ? StOk : StBadIndex;
      end
      S_LAST: begin
        first_q <= rd_x;
      end
      S_LASTD: begin
        last_q <= rd_x;
        asc_q  <= $signed(rd_x) >= $signed(first_q);
        lo_q   <= '0;
        hi_q   <= n_q + LenW'(1);
      end
      S_SRCH_CMP: begin
        lo_q <= lo_n;
        hi_q <= hi_n;
      end
      S_SEL: begin
        j_q <= j_sel;
        if (j_sel == '0) begin
          res_seg_q <= 8'd1;
          res_st_q  <= asc_q ? StBelow : StAbove;
        end else if (j_sel >= n_q) begin
          res_seg_q <= 8'(n_q - LenW'(1));
          res_st_q  <= asc_q ? StAbove : StBelow;
        end else begin
          res_seg_q <= j_sel[7:0];
          res_st_q  <= StOk;
        end
      end
      S_CLAMP: begin
        res_y_q <= rd_y;
      end
      S_RDL: begin
        lx_q <= rd_x;
        ly_q <= rd_y;
      end
      S_RDR: begin
        rx_q <= rd_x;
        ry_q <= rd_y;
      end
      S_DIFF: begin
        ax_q    <= dx[32] ? 32'(-dx) : dx[31:0];
        ay_q    <= dy[32] ? 32'(-dy) : dy[31:0];
        aq_q    <= dq[32] ? 32'(-dq) : dq[31:0];
        neg_q   <= dx[32] ^ dy[32] ^ dq[32];
        degen_q <= (dx == '0) || (dy == '0) || (dq == '0);
      end
      S_MUL: begin
        w_q     <= ay_q * aq_q;
        rem_q   <= '0;
        cnt_q   <= '0;
        res_y_q <= ly_q;
      end
      S_DIV: begin
        w_q   <= w_div;
        rem_q <= w_rem;
        cnt_q <= cnt_q + 5'd1;
      end
      S_RND: begin
        corr_q <= (quo_r > 65'h2_0000_0000) ? 34'h2_0000_0000 : quo_r[33:0];
      end
      S_SUM: begin
        if ($signed(sum_ext) > $signed(36'sh0_7FFF_FFFF)) begin
          res_y_q <= 32'h7FFF_FFFF;
        end else if ($signed(sum_ext) < $signed(-36'sh0_8000_0000)) begin
          res_y_q <= 32'h8000_0000;
        end else begin
          res_y_q <= sum_ext[31:0];
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_y_q   <= res_y_q;
          out_seg_q <= res_seg_q;
          out_st_q  <= res_st_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_st_q, out_seg_q, out_y_q};

endmodule

// ----- tb/pwl_checker.sv -----
// ----------------------------------------------------------------------------
// pwl_checker
// watches the config port and both streams of the interpolator, predicts the
// result of every input beat from its own knot table, and compares each
// output beat with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pwl_checker
  import pwl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  output int          pending_o,
  output int          fail_count_o
);

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         segment_index;
    logic signed [31:0] y_result;
  } interp_result_t;

  logic signed [31:0] knot_x [TableDepth];
  logic signed [31:0] knot_y [TableDepth];
  logic [LenW-1:0]    knot_count;
  interp_result_t     result_fifo [$];

  function automatic int unsigned used_length();
    if (knot_count < 2) return 2;
    if (knot_count > TableDepth) return TableDepth;
    return knot_count;
  endfunction

  function automatic logic signed [31:0] lerp(longint lx, longint ly, longint rx,
                                              longint ry, longint q);
    longint      dx, dy, dq, res;
    logic [63:0] ax, ay, aq, prod, quo, rem;
    bit          neg;
    dx = rx - lx;
    dy = ry - ly;
    dq = q - lx;
    if (dx == 0 || dy == 0 || dq == 0) return ly[31:0];
    ax   = (dx < 0) ? -dx : dx;
    ay   = (dy < 0) ? -dy : dy;
    aq   = (dq < 0) ? -dq : dq;
    neg  = ((dx < 0) != (dy < 0)) != (dq < 0);
    prod = ay * aq;
    quo  = prod / ax;
    rem  = prod % ax;
    if (rem >= ax - rem) quo++;
    if (quo > 64'h2_0000_0000) quo = 64'h2_0000_0000;
    res = neg ? ly - longint'(quo) : ly + longint'(quo);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  function automatic interp_result_t predict_beat(logic op, logic [7:0] idx,
                                                  logic signed [31:0] xv,
                                                  logic signed [31:0] yv);
    interp_result_t     r;
    int unsigned        n, lo, hi, mid, j;
    logic signed [31:0] first, last;
    bit                 asc, ge;
    r = '0;
    n = used_length();
    if (op == OpWrite) begin
      if (idx >= n) begin
        r.status = StBadIndex;
      end else begin
        knot_x[idx] = xv;
        knot_y[idx] = yv;
      end
      return r;
    end
    first = knot_x[0];
    last  = knot_x[n-1];
    asc   = last >= first;
    lo    = 0;
    hi    = n + 1;
    while (hi - lo > 1) begin
      mid = (hi + lo) >> 1;
      ge  = xv >= knot_x[mid-1];
      if (ge == asc) lo = mid;
      else hi = mid;
    end
    if (xv == first) j = 1;
    else if (xv == last) j = n - 1;
    else j = lo;
    if (j == 0) begin
      r.y_result      = knot_y[0];
      r.segment_index = 8'd1;
      r.status        = asc ? StBelow : StAbove;
    end else if (j >= n) begin
      r.y_result      = knot_y[n-1];
      r.segment_index = 8'(n - 1);
      r.status        = asc ? StAbove : StBelow;
    end else begin
      r.y_result      = lerp(knot_x[j-1], knot_y[j-1], knot_x[j], knot_y[j], xv);
      r.segment_index = 8'(j);
      r.status        = StOk;
    end
    return r;
  endfunction

  assign pending_o = result_fifo.size();

  always @(posedge clk_i or negedge rst_ni) begin
    interp_result_t exp_r, got_r;
    int             errs;
    if (!rst_ni) begin
      knot_count   <= 9'd2;
      fail_count_o <= 0;
      result_fifo.delete();
    end else begin
      errs = 0;
      if (cfg_we_i) knot_count <= cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got_r = m_axis_tdata[41:0];
        if (result_fifo.size() == 0) begin
          $error("output beat with nothing expected: %h", m_axis_tdata);
          errs++;
        end else begin
          exp_r = result_fifo.pop_front();
          if (got_r.y_result !== exp_r.y_result) begin
            $error("y_result expected %0d actual %0d", exp_r.y_result, got_r.y_result);
            errs++;
          end
          if (got_r.segment_index !== exp_r.segment_index) begin
            $error("segment_index expected %0d actual %0d",
                   exp_r.segment_index, got_r.segment_index);
            errs++;
          end
          if (got_r.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, got_r.status);
            errs++;
          end
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (s_axis_tvalid && s_axis_tready)
        result_fifo.push_back(predict_beat(s_axis_tuser[0], s_axis_tdata[7:0],
                                           s_axis_tdata[39:8], s_axis_tdata[71:40]));
    end
  end

endmodule

// ----- tb/piecewise_linear_table_interp_core_tb.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_core_tb
// drives knot writes and interpolation queries through the stream ports with
// random gaps and back pressure, over ascending, descending, unsorted and
// flat tables of many lengths; a side checker predicts and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module piecewise_linear_table_interp_core_tb;
  import pwl_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam int ItemTarget = 1400;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [8:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  int          pending;
  int          fail_count;
  int          cycles;
  int          n_writes, n_queries, n_phases;
  bit          no_gaps;

  logic signed [31:0] tab_x [TableDepth];
  logic signed [31:0] tab_y [TableDepth];

  piecewise_linear_table_interp_core u_top (.*);

  pwl_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(negedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  int ready_hold;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= 0;
    end else if (ready_hold > 0) begin
      ready_hold    <= ready_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      ready_hold    <= gap_len();
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_beat(logic op, logic [7:0] idx, logic [31:0] xv, logic [31:0] yv);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {yv, xv, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (op == OpWrite) n_writes++;
    else n_queries++;
  endtask

  task automatic set_length(logic [8:0] len);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic int unsigned eff_len(logic [8:0] len);
    if (len < 2) return 2;
    if (len > TableDepth) return TableDepth;
    return len;
  endfunction

  // fills tab_x / tab_y with a table of the given shape
  task automatic build_table(int unsigned n, int shape);
    int xs [$];
    int span;
    bit wide;
    wide = $urandom_range(0, 2) == 0;
    span = $urandom_range(16, 1 << 20);
    for (int i = 0; i < n; i++) begin
      if (wide) xs.push_back($urandom);
      else xs.push_back(int'($urandom_range(0, span)) - span / 2);
      tab_y[i] = wide || $urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 22);
    end
    case (shape)
      0: xs.sort();
      1: xs.rsort();
      2: ;
      3: begin
        xs.sort();
        for (int i = 1; i < n; i++) if ($urandom_range(0, 3) == 0) xs[i] = xs[i-1];
      end
      default: for (int i = 1; i < n; i++) xs[i] = xs[0];
    endcase
    for (int i = 0; i < n; i++) tab_x[i] = xs[i];
  endtask

  task automatic load_table(int unsigned n);
    int unsigned order [$];
    for (int i = 0; i < n; i++) order.push_back(i);
    order.shuffle();
    foreach (order[k]) begin
      send_beat(OpWrite, 8'(order[k]), tab_x[order[k]], tab_y[order[k]]);
      if (n < TableDepth && $urandom_range(0, 7) == 0)
        send_beat(OpWrite, 8'($urandom_range(n, 255)), $urandom, $urandom);
    end
  endtask

  task automatic random_query(int unsigned n);
    int          r, j;
    longint      a, b, lo, hi;
    logic [31:0] q;
    r = $urandom_range(0, 99);
    j = $urandom_range(1, n - 1);
    a = tab_x[j-1];
    b = tab_x[j];
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (r < 45) q = 32'(lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1)));
    else if (r < 60) q = tab_x[$urandom_range(0, n - 1)];
    else if (r < 70) q = 32'(tab_x[0] - $urandom_range(0, 1000));
    else if (r < 80) q = 32'(tab_x[n-1] + $urandom_range(0, 1000));
    else if (r < 85) q = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    else q = $urandom;
    send_beat(OpQuery, 8'($urandom), q, $urandom);
  endtask

  initial begin
    logic [8:0]  len;
    int unsigned n;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cycles        = 0;
    n_writes      = 0;
    n_queries     = 0;
    n_phases      = 0;
    no_gaps       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: two knots at the extremes, both directions, flat segment
    set_length(9'd2);
    send_beat(OpWrite, 8'd0, 32'h8000_0000, 32'h7fff_ffff);
    send_beat(OpWrite, 8'd1, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(OpWrite, 8'd255, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(OpWrite, 8'd2, 32'h1234_5678, 32'h0);
    send_beat(OpQuery, 8'hff, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OpQuery, 8'h00, 32'h7fff_ffff, 32'h0);
    send_beat(OpQuery, 8'h00, 32'h0, 32'h0);
    send_beat(OpQuery, 8'h00, 32'h7fff_fffe, 32'h0);
    send_beat(OpWrite, 8'd0, 32'h7fff_ffff, 32'h0001_0000);
    send_beat(OpWrite, 8'd1, 32'h8000_0000, 32'hffff_0000);
    send_beat(OpQuery, 8'h00, 32'h0, 32'h0);
    send_beat(OpQuery, 8'h00, 32'h8000_0000, 32'h0);
    send_beat(OpQuery, 8'h00, 32'h7fff_ffff, 32'h0);
    send_beat(OpWrite, 8'd0, 32'd5, 32'h0000_0300);
    send_beat(OpWrite, 8'd1, 32'd5, 32'h8000_0000);
    send_beat(OpQuery, 8'h00, 32'd5, 32'h0);
    send_beat(OpQuery, 8'h00, 32'd4, 32'h0);
    send_beat(OpQuery, 8'h00, 32'd6, 32'h0);
    set_length(9'd3);
    send_beat(OpWrite, 8'd0, 32'h0, 32'h8000_0000);
    send_beat(OpWrite, 8'd1, 32'd1, 32'h7fff_ffff);
    send_beat(OpWrite, 8'd2, 32'h7fff_ffff, 32'h8000_0000);
    send_beat(OpQuery, 8'h00, 32'h4000_0000, 32'h0);
    send_beat(OpQuery, 8'h00, 32'd1, 32'h0);

    while (n_writes + n_queries < ItemTarget) begin
      case (n_phases % 12)
        2:  len = 9'd256;
        5:  len = 9'd511;
        7:  len = 9'd0;
        9:  len = 9'd1;
        default: len = 9'($urandom_range(2, 24));
      endcase
      n_phases++;
      no_gaps = (n_phases % 4) == 3;
      n = eff_len(len);
      set_length(len);
      build_table(n, $urandom_range(0, 5) % 5);
      load_table(n);
      repeat ($urandom_range(20, 60)) random_query(n);
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("%0d knot writes and %0d queries over %0d table settings", n_writes,
             n_queries, n_phases + 2);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pwl_pkg.sv
rtl/pwl_ram.sv
rtl/piecewise_linear_table_interp_core.sv
tb/pwl_checker.sv
tb/piecewise_linear_table_interp_core_tb.sv
